FILE: design/text_console_writer_top_defines.svh
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tcw_pkg.sv
// shared constants and types for the text console writer
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } tcw_mem_req_t;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scroll;
    } tcw_result_t;

endpackage

`default_nettype wire

FILE: design/tcw_screen_ram.sv
// screen cell memory, one write port and one registered read port
`default_nettype none

module tcw_screen_ram
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire tcw_mem_req_t      req,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tcw_engine.sv
// cursor and sequencer: put, clear, read, scroll copy and sweeps
`default_nettype none

module tcw_engine
    import tcw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    op,
    input  wire logic [CHAR_W-1:0]  char_code,
    input  wire logic [IDX_W-1:0]   cell_index,
    input  wire logic [7:0]         colour,
    output tcw_mem_req_t            mem_req,
    input  wire logic [CELL_W-1:0]  mem_rdata,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output tcw_result_t             res
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   ctr_reg, ctr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [CELL_W-1:0]  value_reg, value_next;
    logic               scroll_reg, scroll_next;
    logic               adv_line;
    logic [CELL_W-1:0]  blank_cell;

    assign blank_cell = {colour, CH_SPACE};
    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res.value  = value_reg;
    assign res.row    = row_reg;
    assign res.col    = col_reg;
    assign res.scroll = scroll_reg;

    always_comb
    begin
        state_next  = state_reg;
        ctr_next    = ctr_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        value_next  = value_reg;
        scroll_next = scroll_reg;
        adv_line    = 1'b0;
        mem_req     = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // power-up sweep in the fixed reset colour
                mem_req.we    = 1'b1;
                mem_req.waddr = ctr_reg[ADDR_W-1:0];
                mem_req.wdata = RESET_CELL;
                if (ctr_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                    ctr_next   = '0;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = '0;
                    scroll_next = 1'b0;
                    state_next  = ST_DONE;
                    unique case (op)
                        OP_PUT:
                        begin
                            if (char_code == CH_NEWLINE)
                            begin
                                adv_line = 1'b1;
                            end
                            else if (char_code == CH_RETURN)
                            begin
                                col_next = '0;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = base_reg + ADDR_W'(col_reg);
                                mem_req.wdata = {colour, char_code};
                                if (col_reg == COL_W'(COLUMNS - 1))
                                begin
                                    adv_line = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end

                        OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            ctr_next   = '0;
                            state_next = ST_BLANK;
                        end

                        OP_READ:
                        begin
                            if (32'(cell_index) < 32'(CELLS))
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_W'(cell_index);
                                state_next    = ST_READ;
                            end
                        end

                        default:
                        begin
                            // unused op only reports the cursor
                        end
                    endcase

                    if (adv_line)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_W'(ROWS - 1))
                        begin
                            scroll_next = 1'b1;
                            ctr_next    = CNT_W'(COLUMNS);
                            state_next  = ST_SCROLL;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + ADDR_W'(COLUMNS);
                        end
                    end
                end
            end

            ST_READ:
            begin
                value_next = mem_rdata;
                state_next = ST_DONE;
            end

            ST_SCROLL:
            begin
                // read cell ctr, write the previous read one row up
                if (ctr_reg < CNT_W'(CELLS))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ctr_reg[ADDR_W-1:0];
                end
                if (ctr_reg > CNT_W'(COLUMNS))
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ADDR_W'(ctr_reg - CNT_W'(COLUMNS) - 1'b1);
                    mem_req.wdata = mem_rdata;
                end
                if (ctr_reg == CNT_W'(CELLS))
                begin
                    ctr_next   = CNT_W'((ROWS - 1) * COLUMNS);
                    state_next = ST_BLANK;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end

            ST_BLANK:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ctr_reg[ADDR_W-1:0];
                mem_req.wdata = blank_cell;
                if (ctr_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            ctr_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            base_reg   <= '0;
            scroll_reg <= 1'b0;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ctr_reg    <= ctr_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            base_reg   <= base_next;
            scroll_reg <= scroll_next;
            value_reg  <= value_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/text_console_writer_top.sv
// top level of the text console writer: config, engine, screen memory, output register
//
//  channel | signals                                          | request moves
//  --------+--------------------------------------------------+--------------------------------
//  in      | in_valid/in_ready, op, char_code, cell_index     | one put, clear or read request
//  out     | out_valid/out_ready, cell_value, cursor_row,     | one result per request
//          | cursor_column, did_scroll                        |
//  cfg     | cfg_write_en, cfg_index, cfg_data                | colour register write, no wait
//
// after reset the engine sweeps the screen memory to blank cells, all CELLS (2000) of them,
// and takes no request during that sweep; config writes are taken throughout
// put character, return, newline without scroll: idle, then done; read cell: idle, read, then done
// scroll (newline or right edge wrap on the bottom row): a row copy through the screen memory,
// reading each cell below the top row and writing it back one row up,
// then blanking the COLUMNS cells of the bottom row
// clear screen: every cell blanked, one memory write per cycle
// the output register frees the engine while a result waits on out_ready
`default_nettype none
`include "text_console_writer_top_defines.svh"

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration writes
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [CHAR_W-1:0]    char_code,
    input  wire logic [IDX_W-1:0]     cell_index,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CELL_W-1:0]         cell_value,
    output logic [ROW_W-1:0]          cursor_row,
    output logic [COL_W-1:0]          cursor_column,
    output logic                      did_scroll
);

    // colour registers, reset to white on black
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [7:0]         colour;

    // engine to memory and engine to output register
    tcw_mem_req_t       mem_req;
    logic [CELL_W-1:0]  mem_rdata;
    logic               res_valid;
    logic               res_ready;
    tcw_result_t        res;

    // output register
    logic               out_valid_reg;
    tcw_result_t        out_reg;

    // reported cursor sits at the start of the bottom row
    logic               bottom_start;

    assign colour = {bg_reg, fg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= COLOR_W'(15);
            bg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FOREGROUND: fg_reg <= cfg_data;
                CFG_BACKGROUND: bg_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    tcw_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .colour     (colour),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    tcw_screen_ram u_screen_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // the result slot takes a new result when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_value    = out_reg.value;
    assign cursor_row    = out_reg.row;
    assign cursor_column = out_reg.col;
    assign did_scroll    = out_reg.scroll;

    assign bottom_start = (cursor_row == ROW_W'(ROWS - 1)) && (cursor_column == '0);

    // one request at a time: the engine is busy the cycle after it takes one
    `TCW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "back to back accept")

    // a scroll always leaves the cursor at the start of the bottom row
    `TCW_ASSERT_SAME(a_scroll_cursor, out_valid && did_scroll, bottom_start, "cursor after scroll")

    // while idle the memory is written only by an accepted put
    `TCW_ASSERT_SAME(a_idle_write, mem_req.we && in_ready, in_valid && op == OP_PUT, "idle write")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the text console writer: random requests, cursor and cell tracking
module tb;
    import tcw_pkg::*;

    // the block reports the cursor for this op and changes nothing
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int CYCLE_LIMIT      = 12_000_000;
    localparam int PHASE_REQUESTS   = 90;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int LONG_HOLD_AFTER  = 150;
    // a late result could trail a scroll or clear by a full memory pass
    localparam int DRAIN_CYCLES     = CELLS + 16;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } console_req_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_FOREGROUND;
    logic [COLOR_W-1:0]   cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      op           = OP_PUT;
    logic [CHAR_W-1:0]    char_code    = '0;
    logic [IDX_W-1:0]     cell_index   = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_W-1:0]     cursor_column;
    logic                 did_scroll;

    text_console_writer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .did_scroll    (did_scroll)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // requests waiting to be offered, and the reports they will produce
    console_req_t queued_requests[$];
    tcw_result_t  predicted_reports[$];

    // shadow copy of the screen, cursor and colour registers
    logic [CELL_W-1:0]  screen_img [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg_colour = 4'hF;
    logic [COLOR_W-1:0] bg_colour = 4'h0;

    bit failed         = 1'b0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int send_burst     = 0;
    int stall_left     = 0;
    int take_burst     = 0;
    bit long_hold_done = 1'b0;

    // ------------------------------------------------------------------
    // screen shadow
    // ------------------------------------------------------------------

    // colour byte from the registers as they are now, character below it
    function automatic logic [CELL_W-1:0] colour_cell(input logic [CHAR_W-1:0] ch);
        return {bg_colour, fg_colour, ch};
    endfunction

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = colour_cell(CH_SPACE);
        cur_row = 0;
        cur_col = 0;
    endtask

    // every row moves up one, bottom row goes blank in the current colour
    task automatic scroll_screen();
        for (int i = COLUMNS; i < CELLS; i++)
            screen_img[i - COLUMNS] = screen_img[i];
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
            screen_img[i] = colour_cell(CH_SPACE);
    endtask

    task automatic line_feed(output bit scrolled);
        scrolled = 1'b0;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            scroll_screen();
            cur_row = ROWS - 1;
            scrolled = 1'b1;
        end
    endtask

    // one accepted request: update the shadow and queue the report it gives
    task automatic apply_console_request(input console_req_t req);
        tcw_result_t rpt;
        bit          scrolled;
        rpt.value = '0;
        scrolled = 1'b0;
        case (req.op)
            OP_PUT:
            begin
                if (req.ch == CH_NEWLINE)
                    line_feed(scrolled);
                else if (req.ch == CH_RETURN)
                    cur_col = 0;
                else
                begin
                    screen_img[cur_row * COLUMNS + cur_col] = colour_cell(req.ch);
                    cur_col++;
                    // right edge wraps like a newline
                    if (cur_col >= COLUMNS)
                        line_feed(scrolled);
                end
            end
            OP_CLEAR:
                blank_screen();
            OP_READ:
            begin
                // out of range reads give zero
                if (req.idx < CELLS)
                    rpt.value = screen_img[req.idx];
            end
            default:
                ;
        endcase
        rpt.row    = cur_row[ROW_W-1:0];
        rpt.col    = cur_col[COL_W-1:0];
        rpt.scroll = scrolled;
        predicted_reports.push_back(rpt);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_request(input logic [OP_W-1:0] o, input logic [CHAR_W-1:0] c,
                                 input logic [IDX_W-1:0] i);
        console_req_t req;
        req.op  = o;
        req.ch  = c;
        req.idx = i;
        queued_requests.push_back(req);
    endtask

    // any byte but the two control codes
    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_RETURN)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    // mostly on screen, now and then past the last cell
    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
        return IDX_W'($urandom_range(0, CELLS - 1));
    endfunction

    // mostly no gap or a short one, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // text lines dominate so the cursor walks down, wraps and scrolls;
    // reads, clears, unused ops and raw requests fill in the rest
    task automatic queue_random_phase(input int count);
        int n;
        int pick;
        int len;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                // short lines keep scrolls coming, long ones cross the right edge
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90)
                                                  : $urandom_range(0, 5);
                repeat (len)
                    queue_request(OP_PUT, text_char(), random_index());
                queue_request(OP_PUT, ($urandom_range(0, 6) == 0) ? CH_RETURN : CH_NEWLINE,
                              random_index());
                n += len + 1;
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 3);
                repeat (len)
                    queue_request(OP_READ, CHAR_W'($urandom_range(0, 255)), random_index());
                n += len;
            end
            else if (pick < 92)
            begin
                queue_request(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), random_index());
                n++;
            end
            else if (pick < 95)
            begin
                queue_request(OP_NONE, CHAR_W'($urandom_range(0, 255)), random_index());
                n++;
            end
            else
            begin
                queue_request(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2 ** IDX_W - 1)));
                n++;
            end
        end
    endtask

    // nothing queued, nothing offered, nothing owed, engine taking requests
    task automatic wait_for_idle();
        @(negedge clk);
        while (!(queued_requests.size() == 0 && !in_valid &&
                 predicted_reports.size() == 0 && in_ready))
            @(negedge clk);
    endtask

    // both colour registers, one write per cycle, only while idle
    task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_FOREGROUND;
        cfg_data     <= fg;
        fg_colour = fg;
        @(posedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data  <= bg;
        bg_colour = bg;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // request driver: offers queued requests with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        console_req_t req_taken;
        console_req_t req_next;
        bit           launch;
        launch = 1'b0;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // predict at the accepting edge, from the payload that was held
            if (in_valid && in_ready)
            begin
                req_taken.op  = op;
                req_taken.ch  = char_code;
                req_taken.idx = cell_index;
                apply_console_request(req_taken);
            end
            // slot is free unless a request is still waiting on in_ready
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_requests.size() > 0)
                begin
                    req_next = queued_requests.pop_front();
                    op         <= req_next.op;
                    char_code  <= req_next.ch;
                    cell_index <= req_next.idx;
                    in_valid   <= 1'b1;
                    launch = 1'b1;
                    // occasional stretches with no gaps at all
                    if (send_burst > 0)
                    begin
                        send_burst--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = idle_length();
                        if ($urandom_range(0, 24) == 0)
                            send_burst = $urandom_range(10, 40);
                    end
                end
                if (!launch)
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, field by field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_reports
        tcw_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_reports.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    if (cell_value !== want.value)
                    begin
                        $error("cell_value: expected %h, actual %h", want.value, cell_value);
                        failed = 1'b1;
                    end
                    if (cursor_row !== want.row)
                    begin
                        $error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
                        failed = 1'b1;
                    end
                    if (cursor_column !== want.col)
                    begin
                        $error("cursor_column: expected %0d, actual %0d",
                               want.col, cursor_column);
                        failed = 1'b1;
                    end
                    if (did_scroll !== want.scroll)
                    begin
                        $error("did_scroll: expected %0d, actual %0d", want.scroll, did_scroll);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER &&
                     queued_requests.size() > 20)
            begin
                // one long hold while the sender keeps going, so the block backs up
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (take_burst > 0)
                    take_burst--;
                else
                begin
                    stall_left = idle_length();
                    if ($urandom_range(0, 24) == 0)
                        take_burst = $urandom_range(10, 40);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed requests, then colour phases of random text
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        int phase;

        // screen after reset: blank in the reset colour
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = RESET_CELL;
        cur_row = 0;
        cur_col = 0;

        // directed: reset contents, field extremes, every op, control codes
        queue_request(OP_READ, 8'h00, 11'd0);
        queue_request(OP_READ, 8'hFF, IDX_W'(CELLS - 1));
        queue_request(OP_READ, 8'h00, IDX_W'(CELLS));    // first index past the screen
        queue_request(OP_READ, 8'h00, 11'h7FF);
        queue_request(OP_PUT, 8'h48, 11'h000);
        queue_request(OP_PUT, 8'h00, 11'h7FF);
        queue_request(OP_PUT, 8'hFF, 11'h555);
        queue_request(OP_PUT, 8'h80, 11'h2AA);
        queue_request(OP_READ, 8'h00, 11'd0);
        queue_request(OP_READ, 8'h00, 11'd3);
        queue_request(OP_PUT, CH_RETURN, 11'd0);         // column back to zero
        queue_request(OP_PUT, 8'h58, 11'd0);             // overwrites the first cell
        queue_request(OP_READ, 8'h00, 11'd0);
        queue_request(OP_PUT, CH_NEWLINE, 11'd0);        // down one row, no scroll
        queue_request(OP_PUT, 8'h7F, 11'd0);
        queue_request(OP_READ, 8'h00, IDX_W'(COLUMNS));
        queue_request(OP_NONE, 8'hFF, 11'h7FF);          // unused op
        queue_request(OP_CLEAR, 8'h00, 11'd0);
        queue_request(OP_READ, 8'h00, 11'd0);
        queue_request(OP_READ, 8'h00, IDX_W'(COLUMNS));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // each phase starts only after every report of the last one has come
        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_idle();
            case (phase)
                0: set_colours(4'h0, 4'h0);
                1: set_colours(4'hF, 4'hF);
                2: set_colours(4'hA, 4'h5);
                default: set_colours(COLOR_W'($urandom_range(0, 15)),
                                     COLOR_W'($urandom_range(0, 15)));
            endcase
            queue_random_phase(PHASE_REQUESTS);
        end

        wait_for_idle();
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed && predicted_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: text_console_writer_top.f
+incdir+design
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/tcw_engine.sv
design/text_console_writer_top.sv
tb/tb.sv
